// ----- src/drs_pkg.sv -----
// drs_pkg: types, codes and constants shared by the relay sequencer files
// no dependencies; imported by drs_step, drs_out_buf, dual_input_relay_sequencer, drs_checker and tb
package drs_pkg;

   // sequencer phases; code 7 has no meaning and falls back to idle
   typedef enum logic [2:0] {
      PH_IDLE    = 3'd0,
      PH_ARMED   = 3'd1,
      PH_RELAY_ON = 3'd2,
      PH_ORANGE  = 3'd3,
      PH_RELEASE = 3'd4,
      PH_OFF_WAIT = 3'd5,
      PH_QUIET   = 3'd6
   } phase_type;

   // configuration register indexes
   localparam logic [2:0] CSR_ARM_DELAY      = 3'd0;
   localparam logic [2:0] CSR_HOLD_DELAY     = 3'd1;
   localparam logic [2:0] CSR_OFF_WAIT       = 3'd2;
   localparam logic [2:0] CSR_QUIET_INTERVAL = 3'd3;
   localparam logic [2:0] CSR_QUIET_LIMIT    = 3'd4;
   localparam logic [2:0] CSR_BROWN_ENABLE   = 3'd5;

   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 16;

   // fixed timer loads, in seconds
   localparam logic [15:0] RETRIGGER_DELAY = 16'd15;
   localparam logic [15:0] SHORT_DELAY     = 16'd1;
   localparam logic [15:0] RETURN_DELAY    = 16'd2;

   // relay masks: bit0 tor1, bit1 tor2, bit2 out1, bit3 out2, bit4 out3
   localparam logic [4:0] ALL_RELAYS   = 5'h1F;
   localparam logic [4:0] RELEASE_MASK = 5'h0F;
   localparam logic [4:0] OUT3_MASK    = 5'h10;

   typedef struct packed {
      logic [15:0] arm_delay;
      logic [15:0] hold_delay;
      logic [15:0] off_wait;
      logic [15:0] quiet_interval;
      logic [7:0]  quiet_limit;
      logic        brown_pulse_enable;
   } cfg_type;

   localparam cfg_type CFG_RESET = '{
      arm_delay:          16'd15,
      hold_delay:         16'd15,
      off_wait:           16'd360,
      quiet_interval:     16'd60,
      quiet_limit:        8'd15,
      brown_pulse_enable: 1'b0
   };

   typedef struct packed {
      phase_type   phase;
      logic [15:0] countdown;
      logic        cd_active;
      logic        cd_done;
      logic [7:0]  quiet_count;
      logic [4:0]  relay_store;
   } seq_state_type;

   localparam seq_state_type SEQ_RESET = '{
      phase:       PH_IDLE,
      countdown:   16'd0,
      cd_active:   1'b0,
      cd_done:     1'b1,
      quiet_count: 8'd0,
      relay_store: 5'd0
   };

   typedef struct packed {
      logic [4:0] relay_levels;
      logic       orange_pulse;
      logic       brown_pulse;
      logic [2:0] phase_now;
   } rsp_type;

endpackage

// ----- src/drs_step.sv -----
// drs_step: one sample's update of timer and phase sequencer, combinational
// depends on drs_pkg
module drs_step
   import drs_pkg::*;
(
   input  seq_state_type cur,
   input  cfg_type       cfg,
   input  logic          second_tick,
   input  logic          level_a,
   input  logic          level_b,
   output seq_state_type nxt,
   output rsp_type       rsp
);

   always_comb begin
      seq_state_type s;
      logic          trig;
      logic          orange;
      logic          brown;
      logic          start;
      logic [15:0]   load;

      s      = cur;
      trig   = !level_a || !level_b;
      orange = 1'b0;
      brown  = 1'b0;
      start  = 1'b0;
      load   = 16'd0;

      // tick goes first
      if (second_tick && s.cd_active) begin
         if (s.countdown != 16'd0) begin
            s.countdown = s.countdown - 16'd1;
         end else begin
            s.cd_done   = 1'b1;
            s.cd_active = 1'b0;
         end
      end

      if (s.cd_done) begin
         case (s.phase)
            PH_IDLE: begin
               if (trig) begin
                  start   = 1'b1;
                  load    = cfg.arm_delay;
                  s.phase = PH_ARMED;
               end
            end
            PH_ARMED: begin
               start   = 1'b1;
               load    = SHORT_DELAY;
               s.phase = trig ? PH_RELAY_ON : PH_IDLE;
            end
            PH_RELAY_ON: begin
               s.relay_store = s.relay_store | ALL_RELAYS;
               start   = 1'b1;
               load    = cfg.hold_delay;
               s.phase = PH_ORANGE;
            end
            PH_ORANGE: begin
               orange  = 1'b1;
               start   = 1'b1;
               load    = cfg.hold_delay;
               s.phase = PH_RELEASE;
            end
            PH_RELEASE: begin
               s.relay_store = s.relay_store & ~RELEASE_MASK;
               start   = 1'b1;
               load    = cfg.off_wait;
               s.phase = PH_OFF_WAIT;
            end
            PH_OFF_WAIT: begin
               start = 1'b1;
               if (trig) begin
                  load    = RETURN_DELAY;
                  s.phase = PH_RELAY_ON;
               end else begin
                  s.quiet_count = 8'd0;
                  load    = SHORT_DELAY;
                  s.phase = PH_QUIET;
               end
            end
            PH_QUIET: begin
               start = 1'b1;
               if (s.quiet_count < cfg.quiet_limit) begin
                  if (trig) begin
                     load    = RETRIGGER_DELAY;
                     s.phase = PH_RELAY_ON;
                  end else begin
                     s.quiet_count = s.quiet_count + 8'd1;
                     load          = cfg.quiet_interval;
                  end
               end else begin
                  brown         = cfg.brown_pulse_enable;
                  s.relay_store = s.relay_store & ~OUT3_MASK;
                  load          = RETURN_DELAY;
                  s.phase       = PH_IDLE;
               end
            end
            default: begin
               // unused code: back to idle, timer left alone
               s.phase = PH_IDLE;
            end
         endcase
      end

      if (start) begin
         s.cd_done   = 1'b0;
         s.countdown = load;
         s.cd_active = 1'b1;
      end

      nxt              = s;
      rsp.relay_levels = s.relay_store;
      rsp.orange_pulse = orange;
      rsp.brown_pulse  = brown;
      rsp.phase_now    = s.phase;
   end

endmodule

// ----- src/drs_out_buf.sv -----
// drs_out_buf: two-entry result buffer, output register plus skid entry
// depends on drs_pkg
module drs_out_buf
   import drs_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  rsp_type push_data,
   output logic    full,
   output logic    out_valid,
   input  logic    out_ready,
   output rsp_type out_data
);

   logic    main_valid_ff, main_valid_in;
   logic    skid_valid_ff, skid_valid_in;
   rsp_type main_data_ff, main_data_in;
   rsp_type skid_data_ff, skid_data_in;
   logic    pop;

   assign pop = main_valid_ff && out_ready;

   always_comb begin
      main_valid_in = main_valid_ff;
      skid_valid_in = skid_valid_ff;
      main_data_in  = main_data_ff;
      skid_data_in  = skid_data_ff;
      if (pop) begin
         if (skid_valid_ff) begin
            main_data_in  = skid_data_ff;
            skid_valid_in = 1'b0;
         end else if (push) begin
            main_data_in = push_data;
         end else begin
            main_valid_in = 1'b0;
         end
      end else if (push) begin
         if (!main_valid_ff) begin
            main_data_in  = push_data;
            main_valid_in = 1'b1;
         end else begin
            skid_data_in  = push_data;
            skid_valid_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         main_valid_ff <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         main_valid_ff <= main_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
      main_data_ff <= main_data_in;
      skid_data_ff <= skid_data_in;
   end

   assign full      = skid_valid_ff;
   assign out_valid = main_valid_ff;
   assign out_data  = main_data_ff;

endmodule

// ----- src/dual_input_relay_sequencer.sv -----
// dual_input_relay_sequencer: top level, config registers, sequencer state, result buffer
// depends on drs_pkg, drs_step, drs_out_buf
//
// usage
//  - req channel: one transfer per sample, carrying the one-second tick flag
//    and the two input levels (0 means triggered)
//  - rsp channel: exactly one transfer per req transfer, in order, with the
//    relay levels, the orange and brown pulse requests and the phase after
//    that sample
//  - csr port: write-only, one register per cycle, index and 16-bit data;
//    write only while no result is outstanding
//  - result path: a result is registered into the buffer's output register, or its skid entry
//  - throughput: one sample per cycle while req_ready is high; the sequencer
//    update is a single combinational pass from the held state to the state register
//  - stall: a two-entry result buffer lets one more sample in while the
//    receiver holds off; req_ready drops once both entries are occupied
//  - reset: synchronous; config returns to its defaults, the sequencer to
//    idle with the timer done and all relays off, the buffer empties
module dual_input_relay_sequencer
   import drs_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,

   input  logic                   req_valid,
   output logic                   req_ready,
   input  logic                   req_second_tick,
   input  logic                   req_level_a,
   input  logic                   req_level_b,

   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output logic [4:0]             rsp_relay_levels,
   output logic                   rsp_orange_pulse,
   output logic                   rsp_brown_pulse,
   output logic [2:0]             rsp_phase_now,

   input  logic                   csr_wen,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata
);

   cfg_type       cfg_ff, cfg_in;
   seq_state_type state_ff, state_in;
   seq_state_type step_state;
   rsp_type       step_rsp;
   rsp_type       buf_data;
   logic          buf_full;
   logic          req_xfer;

   // config writes; unknown indexes are dropped
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wen) begin
         case (csr_index)
            CSR_ARM_DELAY:      cfg_in.arm_delay          = csr_wdata;
            CSR_HOLD_DELAY:     cfg_in.hold_delay         = csr_wdata;
            CSR_OFF_WAIT:       cfg_in.off_wait           = csr_wdata;
            CSR_QUIET_INTERVAL: cfg_in.quiet_interval     = csr_wdata;
            CSR_QUIET_LIMIT:    cfg_in.quiet_limit        = csr_wdata[7:0];
            CSR_BROWN_ENABLE:   cfg_in.brown_pulse_enable = csr_wdata[0];
            default:            cfg_in = cfg_ff;
         endcase
      end
   end

   assign req_ready = !buf_full;
   assign req_xfer  = req_valid && req_ready;

   // tick then phase step for the sample on the req ports
   drs_step u_step (
      .cur         (state_ff),
      .cfg         (cfg_ff),
      .second_tick (req_second_tick),
      .level_a     (req_level_a),
      .level_b     (req_level_b),
      .nxt         (step_state),
      .rsp         (step_rsp)
   );

   // state advances only on an accepted transfer
   assign state_in = req_xfer ? step_state : state_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff   <= CFG_RESET;
         state_ff <= SEQ_RESET;
      end else begin
         cfg_ff   <= cfg_in;
         state_ff <= state_in;
      end
   end

   drs_out_buf u_out_buf (
      .clock     (clock),
      .reset     (reset),
      .push      (req_xfer),
      .push_data (step_rsp),
      .full      (buf_full),
      .out_valid (rsp_valid),
      .out_ready (rsp_ready),
      .out_data  (buf_data)
   );

   assign rsp_relay_levels = buf_data.relay_levels;
   assign rsp_orange_pulse = buf_data.orange_pulse;
   assign rsp_brown_pulse  = buf_data.brown_pulse;
   assign rsp_phase_now    = buf_data.phase_now;

`ifndef SYNTH
   // every accepted sample leaves a result to deliver next cycle
   a_rsp_after_req: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> rsp_valid)
      else $error("no result after accepted sample");

   // while the latch phases run, all five relays are on
   a_relays_on: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_phase_now == PH_ORANGE || rsp_phase_now == PH_RELEASE)
         |-> rsp_relay_levels == ALL_RELAYS)
      else $error("relays not all on in latch phases");

   // orange pulse only on the step into release
   a_orange_phase: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_orange_pulse |-> rsp_phase_now == PH_RELEASE)
      else $error("orange pulse outside release step");

   // brown pulse only on the final step back to idle, with out3 dropped
   a_brown_phase: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_brown_pulse |-> rsp_phase_now == PH_IDLE && !rsp_relay_levels[4])
      else $error("brown pulse outside final step");
`endif

endmodule

// ----- sim/drs_checker.sv -----
`timescale 1ns / 100ps
// drs_checker: watches the req, rsp and csr ports of the relay sequencer, predicts
// each result from its own copy of the sequencer state and compares; needs drs_pkg
module drs_checker
   import drs_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,

   input  logic                   req_valid,
   input  logic                   req_ready,
   input  logic                   req_second_tick,
   input  logic                   req_level_a,
   input  logic                   req_level_b,

   input  logic                   rsp_valid,
   input  logic                   rsp_ready,
   input  logic [4:0]             rsp_relay_levels,
   input  logic                   rsp_orange_pulse,
   input  logic                   rsp_brown_pulse,
   input  logic [2:0]             rsp_phase_now,

   input  logic                   csr_wen,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata,

   output int                     error_count,
   output int                     outstanding
);

   cfg_type       settings;
   seq_state_type model;
   rsp_type       relay_updates[$];

   initial begin
      error_count = 0;
      outstanding = 0;
   end

   function automatic void restart_timer(input logic [15:0] seconds);
      model.cd_done   = 1'b0;
      model.countdown = seconds;
      model.cd_active = 1'b1;
   endfunction

   // tick first, then one sequencer step if the timer has run out
   function automatic rsp_type sequencer_step(input logic tick, input logic lvl_a,
                                              input logic lvl_b);
      rsp_type res;
      logic    trig;
      res  = '0;
      trig = !lvl_a || !lvl_b;
      if (tick && model.cd_active) begin
         if (model.countdown != 16'd0) begin
            model.countdown = model.countdown - 16'd1;
         end else begin
            model.cd_done   = 1'b1;
            model.cd_active = 1'b0;
         end
      end
      if (model.cd_done) begin
         case (model.phase)
            PH_IDLE: begin
               if (trig) begin
                  restart_timer(settings.arm_delay);
                  model.phase = PH_ARMED;
               end
            end
            PH_ARMED: begin
               restart_timer(SHORT_DELAY);
               model.phase = trig ? PH_RELAY_ON : PH_IDLE;
            end
            PH_RELAY_ON: begin
               model.relay_store = model.relay_store | ALL_RELAYS;
               restart_timer(settings.hold_delay);
               model.phase = PH_ORANGE;
            end
            PH_ORANGE: begin
               res.orange_pulse = 1'b1;
               restart_timer(settings.hold_delay);
               model.phase = PH_RELEASE;
            end
            PH_RELEASE: begin
               model.relay_store = model.relay_store & ~RELEASE_MASK;
               restart_timer(settings.off_wait);
               model.phase = PH_OFF_WAIT;
            end
            PH_OFF_WAIT: begin
               if (trig) begin
                  restart_timer(RETURN_DELAY);
                  model.phase = PH_RELAY_ON;
               end else begin
                  model.quiet_count = 8'd0;
                  restart_timer(SHORT_DELAY);
                  model.phase = PH_QUIET;
               end
            end
            PH_QUIET: begin
               if (model.quiet_count < settings.quiet_limit) begin
                  if (trig) begin
                     restart_timer(RETRIGGER_DELAY);
                     model.phase = PH_RELAY_ON;
                  end else begin
                     model.quiet_count = model.quiet_count + 8'd1;
                     restart_timer(settings.quiet_interval);
                  end
               end else begin
                  res.brown_pulse   = settings.brown_pulse_enable;
                  model.relay_store = model.relay_store & ~OUT3_MASK;
                  restart_timer(RETURN_DELAY);
                  model.phase = PH_IDLE;
               end
            end
            default: model.phase = PH_IDLE;
         endcase
      end
      res.relay_levels = model.relay_store;
      res.phase_now    = model.phase;
      return res;
   endfunction

   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         settings = CFG_RESET;
         model    = SEQ_RESET;
         relay_updates.delete();
      end else begin
         if (csr_wen) begin
            case (csr_index)
               CSR_ARM_DELAY:      settings.arm_delay          = csr_wdata;
               CSR_HOLD_DELAY:     settings.hold_delay         = csr_wdata;
               CSR_OFF_WAIT:       settings.off_wait           = csr_wdata;
               CSR_QUIET_INTERVAL: settings.quiet_interval     = csr_wdata;
               CSR_QUIET_LIMIT:    settings.quiet_limit        = csr_wdata[7:0];
               CSR_BROWN_ENABLE:   settings.brown_pulse_enable = csr_wdata[0];
               default: ;
            endcase
         end
         // results leave before the new sample is queued
         if (rsp_valid === 1'b1 && rsp_ready) begin
            if (relay_updates.size() == 0) begin
               $error("rsp transfer with no sample outstanding");
               error_count++;
            end else begin
               want = relay_updates.pop_front();
               if (rsp_relay_levels !== want.relay_levels) begin
                  $error("relay_levels expected %0h actual %0h",
                         want.relay_levels, rsp_relay_levels);
                  error_count++;
               end
               if (rsp_orange_pulse !== want.orange_pulse) begin
                  $error("orange_pulse expected %0b actual %0b",
                         want.orange_pulse, rsp_orange_pulse);
                  error_count++;
               end
               if (rsp_brown_pulse !== want.brown_pulse) begin
                  $error("brown_pulse expected %0b actual %0b",
                         want.brown_pulse, rsp_brown_pulse);
                  error_count++;
               end
               if (rsp_phase_now !== want.phase_now) begin
                  $error("phase_now expected %0d actual %0d",
                         want.phase_now, rsp_phase_now);
                  error_count++;
               end
            end
         end
         if (req_valid && req_ready)
            relay_updates.push_back(sequencer_step(req_second_tick, req_level_a, req_level_b));
      end
      outstanding <= relay_updates.size();
   end

endmodule

// ----- sim/tb.sv -----
`timescale 1ns / 100ps
// tb: stimulus and verdict for dual_input_relay_sequencer
// depends on drs_pkg, the sequencer rtl and drs_checker, which does all the checking
module tb;
   import drs_pkg::*;

   localparam int CYCLE_LIMIT     = 200000;
   localparam int IDLE_PCT        = 22;
   localparam int HOLD_OFF_CYCLES = 300;
   localparam int SETTLE_CYCLES   = 4;

   // register slots past the last real register, written to prove they are ignored
   localparam logic [CSR_INDEX_W-1:0] CSR_SPARE_LO = 3'd6;
   localparam logic [CSR_INDEX_W-1:0] CSR_SPARE_HI = 3'd7;

   logic                   clock;
   logic                   reset;
   logic                   req_valid;
   logic                   req_ready;
   logic                   req_second_tick;
   logic                   req_level_a;
   logic                   req_level_b;
   logic                   rsp_valid;
   logic                   rsp_ready;
   logic [4:0]             rsp_relay_levels;
   logic                   rsp_orange_pulse;
   logic                   rsp_brown_pulse;
   logic [2:0]             rsp_phase_now;
   logic                   csr_wen;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0]  csr_wdata;

   int error_count;
   int outstanding;
   int cycle_count = 0;

   // calm turns off idling on both sides; hold_request asks the receiver for one long hold-off
   bit calm = 1'b0;
   bit hold_request = 1'b0;

   dual_input_relay_sequencer dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_second_tick  (req_second_tick),
      .req_level_a      (req_level_a),
      .req_level_b      (req_level_b),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_relay_levels (rsp_relay_levels),
      .rsp_orange_pulse (rsp_orange_pulse),
      .rsp_brown_pulse  (rsp_brown_pulse),
      .rsp_phase_now    (rsp_phase_now),
      .csr_wen          (csr_wen),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata)
   );

   drs_checker u_checker (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_second_tick  (req_second_tick),
      .req_level_a      (req_level_a),
      .req_level_b      (req_level_b),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_relay_levels (rsp_relay_levels),
      .rsp_orange_pulse (rsp_orange_pulse),
      .rsp_brown_pulse  (rsp_brown_pulse),
      .rsp_phase_now    (rsp_phase_now),
      .csr_wen          (csr_wen),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata),
      .error_count      (error_count),
      .outstanding      (outstanding)
   );

   // 20 ns clock
   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // watchdog, generous against the slowest legal run
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("FAILURE");
         $finish;
      end
   end

   // receiver: random stalls, or a long counted hold-off when asked
   initial begin
      int hold_left;
      bit hold_taken;
      hold_left  = 0;
      hold_taken = 1'b0;
      rsp_ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_request && !hold_taken) begin
            hold_left  = HOLD_OFF_CYCLES;
            hold_taken = 1'b1;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= calm || ($urandom_range(99) >= IDLE_PCT);
         end
      end
   end

   // one sample transfer; an optional idle gap first, then valid held until taken
   task automatic offer_sample(input logic tick, input logic lvl_a, input logic lvl_b);
      int gap;
      gap = 0;
      if (!calm)
         while ($urandom_range(99) < IDLE_PCT) gap++;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_second_tick <= tick;
      req_level_a     <= lvl_a;
      req_level_b     <= lvl_b;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
   endtask

   // stop offering and wait until every result is back
   task automatic drain_results();
      req_valid <= 1'b0;
      do @(posedge clock); while (outstanding != 0);
   endtask

   task automatic write_reg(input logic [CSR_INDEX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] value);
      csr_wen   <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
   endtask

   // all six registers back to back, only ever called with the block drained
   task automatic configure(input logic [CSR_DATA_W-1:0] arm, input logic [CSR_DATA_W-1:0] hold,
                            input logic [CSR_DATA_W-1:0] off, input logic [CSR_DATA_W-1:0] quiet,
                            input logic [CSR_DATA_W-1:0] limit,
                            input logic [CSR_DATA_W-1:0] brown);
      write_reg(CSR_ARM_DELAY, arm);
      write_reg(CSR_HOLD_DELAY, hold);
      write_reg(CSR_OFF_WAIT, off);
      write_reg(CSR_QUIET_INTERVAL, quiet);
      write_reg(CSR_QUIET_LIMIT, limit);
      write_reg(CSR_BROWN_ENABLE, brown);
      csr_wen <= 1'b0;
   endtask

   // input levels come in runs so that whole sequences play out: a run either
   // holds some trigger or stays quiet, with stray random levels as noise
   task automatic random_samples(input int count, input int trig_pct, input int tick_pct,
                                 input int noise_pct);
      int         left;
      int         run;
      logic [1:0] levels;
      logic       tick;
      left = count;
      while (left > 0) begin
         run = $urandom_range(40, 1);
         if ($urandom_range(99) < trig_pct)
            levels = 2'($urandom_range(2));    // at least one level low
         else
            levels = 2'b11;
         for (int i = 0; i < run && left > 0; i++) begin
            tick = ($urandom_range(99) < tick_pct);
            if ($urandom_range(99) < noise_pct)
               offer_sample(tick, 1'($urandom_range(1)), 1'($urandom_range(1)));
            else
               offer_sample(tick, levels[1], levels[0]);
            left--;
         end
      end
   endtask

   // walk through the whole sequence with zero delays: {tick, level_a, level_b};
   // ends with a trigger during quiet counting, which goes back to relay on
   logic [2:0] walk [12] = '{3'b101, 3'b110, 3'b111, 3'b111, 3'b111, 3'b111,
                             3'b111, 3'b111, 3'b111, 3'b111, 3'b101, 3'b111};

   initial begin
      reset           <= 1'b1;
      req_valid       <= 1'b0;
      req_second_tick <= 1'b0;
      req_level_a     <= 1'b1;
      req_level_b     <= 1'b1;
      csr_wen         <= 1'b0;
      csr_index       <= CSR_ARM_DELAY;
      csr_wdata       <= '0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // directed: zero delays, three quiet counts, brown pulse on
      configure(16'd0, 16'd0, 16'd0, 16'd0, 16'd3, 16'd1);
      foreach (walk[k])
         offer_sample(walk[k][2], walk[k][1], walk[k][0]);
      // every combination of tick and levels
      for (int k = 0; k < 8; k++)
         offer_sample(k[2], k[1], k[0]);

      // minimum delays, quiet limit zero so out3 drops straight away
      drain_results();
      configure(16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd1);
      random_samples(200, 40, 80, 3);

      // short random delays and limits
      drain_results();
      configure(16'($urandom_range(3)), 16'($urandom_range(3)), 16'($urandom_range(3)),
                16'($urandom_range(3)), 16'($urandom_range(4, 1)), 16'($urandom_range(1)));
      random_samples(450, 35, 75, 3);

      // no idling anywhere, and one long receiver hold-off: the result buffer
      // fills and req_ready must drop while the sender keeps offering
      drain_results();
      configure(16'($urandom_range(2)), 16'($urandom_range(2)), 16'($urandom_range(2)),
                16'($urandom_range(2)), 16'($urandom_range(3, 1)), 16'($urandom_range(1)));
      calm         = 1'b1;
      hold_request = 1'b1;
      random_samples(350, 35, 90, 3);
      calm = 1'b0;

      // long quiet counting up to the largest limit
      drain_results();
      configure(16'd0, 16'd0, 16'd0, 16'd0, 16'd255, 16'd0);
      random_samples(400, 2, 85, 0);

      // stray indexes are ignored, wide data is cut to the register width
      drain_results();
      write_reg(CSR_SPARE_LO, 16'hFFFF);
      write_reg(CSR_SPARE_HI, 16'h1234);
      configure(16'd1, 16'd2, 16'd0, 16'd1, 16'hAB02, 16'h7FF1);
      random_samples(250, 35, 80, 3);

      // largest delays last, since the sequence parks in a long countdown
      drain_results();
      configure(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'h00FF, 16'd1);
      random_samples(100, 50, 90, 3);

      drain_results();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (error_count == 0)
         $display("SUCCESS");
      else
         $display("FAILURE");
      $finish;
   end

endmodule

// ----- sim.f -----
src/drs_pkg.sv
src/drs_step.sv
src/drs_out_buf.sv
src/dual_input_relay_sequencer.sv
sim/drs_checker.sv
sim/tb.sv
